// ===== rtl/hrd_pkg.sv =====
// Shared constants, codes and store access types for the half rotating deque.
package hrd_pkg;

   // Store geometry
   localparam int DEPTH = 1024;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // Word field widths
   localparam int DATA_W  = 32;
   localparam int MODE_W  = 2;
   localparam int POS_W   = 10;
   localparam int ENTRY_W = 11;
   localparam int ERR_W   = 2;
   localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

   // Operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ROT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd3;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;
   localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

   // Store write request; sel picks the physical store
   typedef struct packed {
      logic              en;
      logic              sel;
      logic [IDX_W-1:0]  addr;
      logic [DATA_W-1:0] data;
   } wr_req_type;

   // Store read request
   typedef struct packed {
      logic             sel;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

endpackage

// ===== rtl/hrd_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface hrd_req_if;
   import hrd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] push_value;
   logic [POS_W-1:0]         read_position;

   modport source (output valid, output mode, output push_value, output read_position,
                   input ready);
   modport sink (input valid, input mode, input push_value, input read_position,
                 output ready);
endinterface

interface hrd_rsp_if;
   import hrd_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] out_value;
   logic [ENTRY_W-1:0]       entry_count;
   logic [ERR_W-1:0]         error_code;

   modport source (output valid, output out_value, output entry_count, output error_code,
                   input ready);
   modport sink (input valid, input out_value, input entry_count, input error_code,
                 output ready);
endinterface

// ===== rtl/hrd_wrap_unit.sv =====
// Shared circular index adder: (base + offset) wrapped into the store depth.
module hrd_wrap_unit (
   input  logic [hrd_pkg::IDX_W-1:0] base,
   input  logic [hrd_pkg::CNT_W-1:0] offset,
   output logic [hrd_pkg::IDX_W-1:0] idx
);
   import hrd_pkg::*;

   logic [SUM_W-1:0] sum;
   logic [SUM_W-1:0] wrapped;

   // Sum stays below twice the depth, so one conditional subtract wraps it
   always_comb begin
      sum     = SUM_W'(base) + SUM_W'(offset);
      wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
      idx     = wrapped[IDX_W-1:0];
   end

endmodule

// ===== rtl/hrd_store.sv =====
// The two half stores, one write port and one registered read port shared between them.
module hrd_store (
   input  logic                       clock,
   input  hrd_pkg::wr_req_type        wr,
   input  hrd_pkg::rd_req_type        rd,
   output logic [hrd_pkg::DATA_W-1:0] rd_data
);
   import hrd_pkg::*;

   logic [DATA_W-1:0] mem0 [DEPTH];
   logic [DATA_W-1:0] mem1 [DEPTH];
   logic [DATA_W-1:0] rd0_ff;
   logic [DATA_W-1:0] rd1_ff;
   logic              rsel_ff;

   // Writes
   always_ff @(posedge clock) begin
      if (wr.en && !wr.sel) begin
         mem0[wr.addr] <= wr.data;
      end
      if (wr.en && wr.sel) begin
         mem1[wr.addr] <= wr.data;
      end
   end

   // Registered reads
   always_ff @(posedge clock) begin
      rd0_ff  <= mem0[rd.addr];
      rd1_ff  <= mem1[rd.addr];
      rsel_ff <= rd.sel;
   end

   assign rd_data = rsel_ff ? rd1_ff : rd0_ff;

endmodule

// ===== rtl/half_rotating_deque_top.sv =====
// Top level of the half rotating deque: sequencer, half bookkeeping and response register.
//
//   channel | port    | dir | words
//   --------+---------+-----+------------------------------------------
//   request | req_ch  | in  | mode, push_value, read_position
//   result  | rsp_ch  | out | out_value, entry_count, error_code
//
// From acceptance to a loaded result an item passes decode and the first store
// access, a wait for read data on pop and read, and a read plus a write when one
// entry moves between halves to keep them balanced. A new word is taken only in
// the idle step, once the last item's result is loaded. The pace is set by the
// single read port of the stores and the one shared index adder.
// Reset (synchronous) empties the deque; stores need no clearing pass.
// The next word is taken while a result still waits; a stalled result holds the
// sequencer in its last step until the result register frees.
module half_rotating_deque_top (
   input logic      clock,
   input logic      reset,
   hrd_req_if.sink   req_ch,
   hrd_rsp_if.source rsp_ch
);
   import hrd_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_RDWAIT, S_MV_RD, S_MV_WR, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      MV_NONE, MV_B2F, MV_F2B
   } move_type;

   state_type          state_ff, state_in;
   move_type           mv_ff, mv_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [DATA_W-1:0]  val_ff, val_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [IDX_W-1:0]   fh_ff, fh_in;
   logic [IDX_W-1:0]   bh_ff, bh_in;
   logic [CNT_W-1:0]   fs_ff, fs_in;
   logic [CNT_W-1:0]   bs_ff, bs_in;
   logic               swp_ff, swp_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [DATA_W-1:0]  res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  out_value_ff, out_value_in;
   logic [ENTRY_W-1:0] entry_count_ff, entry_count_in;
   logic [ERR_W-1:0]   error_code_ff, error_code_in;

   logic [CNT_W-1:0]   count;
   logic [IDX_W-1:0]   au_base;
   logic [CNT_W-1:0]   au_off;
   logic [IDX_W-1:0]   au_idx;
   wr_req_type         wr;
   rd_req_type         rd;
   logic [DATA_W-1:0]  rd_data;

   hrd_wrap_unit u_wrap (
      .base   (au_base),
      .offset (au_off),
      .idx    (au_idx)
   );

   hrd_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   assign count = fs_ff + bs_ff;

   // Channel ports
   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_value   = out_value_ff;
   assign rsp_ch.entry_count = entry_count_ff;
   assign rsp_ch.error_code  = error_code_ff;

   // Sequencer next state
   always_comb begin
      state_in       = state_ff;
      mv_in          = mv_ff;
      mode_in        = mode_ff;
      val_in         = val_ff;
      pos_in         = pos_ff;
      fh_in          = fh_ff;
      bh_in          = bh_ff;
      fs_in          = fs_ff;
      bs_in          = bs_ff;
      swp_in         = swp_ff;
      err_in         = err_ff;
      res_in         = res_ff;
      out_value_in   = out_value_ff;
      entry_count_in = entry_count_ff;
      error_code_in  = error_code_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      au_base        = fh_ff;
      au_off         = '0;
      wr             = '0;
      rd             = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in  = req_ch.mode;
               val_in   = req_ch.push_value;
               pos_in   = req_ch.read_position;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            err_in   = ERR_OK;
            res_in   = '0;
            mv_in    = MV_NONE;
            state_in = S_DONE;
            case (mode_ff)
               MODE_PUSH: begin
                  if (count >= CNT_W'(DEPTH)) begin
                     err_in = ERR_FULL;
                  end else begin
                     au_base = bh_ff;
                     au_off  = bs_ff;
                     wr.en   = 1'b1;
                     wr.sel  = ~swp_ff;
                     wr.addr = au_idx;
                     wr.data = val_ff;
                     bs_in   = bs_ff + CNT_W'(1);
                     // back half two longer than front: shift its head over
                     if (bs_ff == fs_ff + CNT_W'(1)) begin
                        mv_in    = MV_B2F;
                        state_in = S_MV_RD;
                     end
                  end
               end
               MODE_POP: begin
                  if (count == '0) begin
                     err_in = ERR_EMPTY;
                  end else begin
                     au_base  = bh_ff;
                     au_off   = bs_ff - CNT_W'(1);
                     rd.sel   = ~swp_ff;
                     rd.addr  = au_idx;
                     bs_in    = bs_ff - CNT_W'(1);
                     mv_in    = (bs_ff == fs_ff) ? MV_F2B : MV_NONE;
                     state_in = S_RDWAIT;
                  end
               end
               MODE_ROT: begin
                  if (count >= CNT_W'(2)) begin
                     fh_in  = bh_ff;
                     bh_in  = fh_ff;
                     fs_in  = bs_ff;
                     bs_in  = fs_ff;
                     swp_in = ~swp_ff;
                     // odd count: new front is one too long
                     if (count[0]) begin
                        mv_in    = MV_F2B;
                        state_in = S_MV_RD;
                     end
                  end
               end
               default: begin
                  if (CMP_W'(pos_ff) >= CMP_W'(count)) begin
                     err_in = ERR_RANGE;
                  end else begin
                     if (CMP_W'(pos_ff) < CMP_W'(fs_ff)) begin
                        au_base = fh_ff;
                        au_off  = CNT_W'(pos_ff);
                        rd.sel  = swp_ff;
                     end else begin
                        au_base = bh_ff;
                        au_off  = CNT_W'(pos_ff) - fs_ff;
                        rd.sel  = ~swp_ff;
                     end
                     rd.addr  = au_idx;
                     state_in = S_RDWAIT;
                  end
               end
            endcase
         end

         // Capture popped or read word
         S_RDWAIT: begin
            res_in   = rd_data;
            state_in = (mv_ff == MV_NONE) ? S_DONE : S_MV_RD;
         end

         // Fetch the entry that changes halves
         S_MV_RD: begin
            if (mv_ff == MV_B2F) begin
               rd.sel  = ~swp_ff;
               rd.addr = bh_ff;
               au_base = bh_ff;
               au_off  = CNT_W'(1);
               bh_in   = au_idx;
               bs_in   = bs_ff - CNT_W'(1);
            end else begin
               au_base = fh_ff;
               au_off  = fs_ff - CNT_W'(1);
               rd.sel  = swp_ff;
               rd.addr = au_idx;
               fs_in   = fs_ff - CNT_W'(1);
            end
            state_in = S_MV_WR;
         end

         // Place it at the tail of the front or the head of the back
         S_MV_WR: begin
            wr.en   = 1'b1;
            wr.data = rd_data;
            if (mv_ff == MV_B2F) begin
               au_base = fh_ff;
               au_off  = fs_ff;
               wr.sel  = swp_ff;
               wr.addr = au_idx;
               fs_in   = fs_ff + CNT_W'(1);
            end else begin
               au_base = bh_ff;
               au_off  = CNT_W'(DEPTH - 1);
               bh_in   = au_idx;
               wr.sel  = ~swp_ff;
               wr.addr = au_idx;
               bs_in   = bs_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end

         // Load the result register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               out_value_in   = res_ff;
               entry_count_in = ENTRY_W'(count);
               error_code_in  = err_ff;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mv_ff        <= MV_NONE;
         fh_ff        <= '0;
         bh_ff        <= '0;
         fs_ff        <= '0;
         bs_ff        <= '0;
         swp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mv_ff        <= mv_in;
         fh_ff        <= fh_in;
         bh_ff        <= bh_in;
         fs_ff        <= fs_in;
         bs_ff        <= bs_in;
         swp_ff       <= swp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      val_ff         <= val_in;
      pos_ff         <= pos_in;
      err_ff         <= err_in;
      res_ff         <= res_in;
      out_value_ff   <= out_value_in;
      entry_count_ff <= entry_count_in;
      error_code_ff  <= error_code_in;
   end

endmodule
